### src/modular_exponentiation_defines.svh
// assertion macros shared by the modular exponentiation rtl
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// condition holds in the same cycle
`define ME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define ME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/modexp_pkg.sv
// types and constants for the modular exponentiation block
`timescale 1ns / 1ps
`default_nettype none
package modexp_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;

    localparam int EXPONENT_RESET = 7;
    localparam int MODULUS_RESET  = 3127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage
`default_nettype wire

### src/modular_exponentiation.sv
// Modular exponentiation top level: right-to-left square-and-multiply sequencer.
// Sequence: reduce the base in the multiplier, then for each exponent bit up to the highest
// set one multiply the accumulator where the bit is set and square below the highest set bit,
// then register the result.
// A new base is taken only in the idle state, after the previous result is registered.
// Reset: synchronous active low; clears control, exponent to 7, modulus to 3127.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_defines.svh"
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]             i_cfg_index,
    input  wire logic [VALUE_BITS-1:0]            i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // base_value
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // power_result
    output logic      [((VALUE_BITS+7)/8)*8-1:0]  m_axis_tdata
);

    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_exponent;
    logic [VALUE_BITS-1:0] r_modulus;
    logic [VALUE_BITS-1:0] r_exp, n_exp;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_sq, n_sq;
    logic [VALUE_BITS-1:0] r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  w_start;
    logic [VALUE_BITS-1:0] w_a;
    logic [VALUE_BITS-1:0] w_b;
    logic [VALUE_BITS-1:0] w_res;
    t_mm_status            w_mm_stat;

    modexp_mulmod #(
        .VALUE_BITS(VALUE_BITS)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_mod    (r_modulus),
        .o_stat   (w_mm_stat),
        .o_result (w_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= VALUE_BITS'(EXPONENT_RESET);
            r_modulus  <= VALUE_BITS'(MODULUS_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_start     = 1'b0;
        w_a         = r_sq;
        w_b         = r_sq;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_exp = r_exponent;
                    if (r_modulus == '0) begin
                        n_acc   = '0;
                        n_state = ST_DONE;
                    end else begin
                        // reduce the base as 1 * base mod m
                        n_acc   = (r_modulus == ONE) ? '0 : ONE;
                        w_start = 1'b1;
                        w_a     = ONE;
                        w_b     = s_axis_tdata[VALUE_BITS-1:0];
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (w_mm_stat.done) begin
                    n_sq    = w_res;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_exp == '0) begin
                    n_state = ST_DONE;
                end else if (r_exp[0]) begin
                    w_start = 1'b1;
                    w_a     = r_acc;
                    n_state = ST_MUL;
                end else begin
                    w_start = 1'b1;
                    n_state = ST_SQR;
                end
            end
            ST_MUL: begin
                if (w_mm_stat.done) begin
                    n_acc = w_res;
                    if (r_exp[VALUE_BITS-1:1] == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        w_start = 1'b1;
                        n_state = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (w_mm_stat.done) begin
                    n_sq    = w_res;
                    n_exp   = r_exp >> 1;
                    n_state = ST_NEXT;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_acc;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out);

    `ME_ASSERT_NOW(a_idle_unit_free, r_state == ST_IDLE, !w_mm_stat.busy,
        "multiplier busy while idle")
    `ME_ASSERT_NOW(a_start_when_free, w_start, !w_mm_stat.busy,
        "multiplier started while busy")
    `ME_ASSERT_NEXT(a_start_runs, w_start, w_mm_stat.busy && (r_state == ST_REDUCE ||
        r_state == ST_MUL || r_state == ST_SQR), "multiply start not followed by work")

endmodule
`default_nettype wire

### src/modexp_mulmod.sv
// bit-serial shift-and-add modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_defines.svh"
module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_a,
    input  wire logic [VALUE_BITS-1:0] i_b,
    input  wire logic [VALUE_BITS-1:0] i_mod,
    output t_mm_status                 o_stat,
    output logic      [VALUE_BITS-1:0] o_result
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(VALUE_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_r;
    logic [VALUE_BITS-1:0] r_a;
    logic [VALUE_BITS-1:0] r_b;

    logic [VALUE_BITS+1:0] w_sum;
    logic [VALUE_BITS+1:0] w_m1;
    logic [VALUE_BITS+1:0] w_m2;
    logic [VALUE_BITS+1:0] n_r;

    // 2r + a*bit is below 3m, so one of three candidates is the residue
    always_comb begin
        w_m1  = {2'b00, i_mod};
        w_m2  = {1'b0, i_mod, 1'b0};
        w_sum = {1'b0, r_r, 1'b0} + (r_b[VALUE_BITS-1] ? {2'b00, r_a} : '0);
        if (w_sum >= w_m2) begin
            n_r = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            n_r = w_sum - w_m1;
        end else begin
            n_r = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= '0;
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            r_r <= n_r[VALUE_BITS-1:0];
            r_b <= {r_b[VALUE_BITS-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_r;

    `ME_ASSERT_NOW(a_result_reduced, r_done, r_r < i_mod, "product not reduced")
    `ME_ASSERT_NEXT(a_last_step_done, r_busy && !i_start && r_cnt == LAST, r_done,
        "last step without done")
    `ME_ASSERT_NEXT(a_done_single, r_done, !r_done, "done held longer than one cycle")

endmodule
`default_nettype wire
